// ----- rtl/vps_pkg.sv -----
// Shared types, widths and register codes for the Verlet particle step block.
package vps_pkg;

  // Fixed-point format of every position and acceleration value
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int DT_W      = 31;

  // Exact product of a signed value and the unsigned dt_squared
  localparam int PROD_W = VAL_W + DT_W;
  // Rounded product after the fraction bits are dropped
  localparam int RND_W  = PROD_W + 1 - FRAC_BITS;
  // 2*pos - prev
  localparam int DBL_W  = VAL_W + 2;
  // Full-precision new position before saturation
  localparam int SUM_W  = ((RND_W > DBL_W) ? RND_W : DBL_W) + 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DT_SQUARED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Y      = 2'd3;

  // Register reset values
  localparam logic [DT_W-1:0]         DT_SQUARED_RST     = 31'd655;
  localparam logic signed [VAL_W-1:0] FLOOR_HEIGHT_RST   = 32'sd0;
  localparam logic signed [VAL_W-1:0] CEILING_HEIGHT_RST = 32'sd6553600;
  localparam logic signed [VAL_W-1:0] GRAVITY_Y_RST      = -32'sd6554;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RND_W-1:0] rnd_t;
  typedef logic signed [DBL_W-1:0] dbl_t;

  typedef struct packed {
    val_t pos_x;
    val_t pos_y;
    val_t pos_z;
    val_t prev_x;
    val_t prev_y;
    val_t prev_z;
    val_t acc_x;
    val_t acc_y;
    val_t acc_z;
  } in_t;

  typedef struct packed {
    val_t out_pos_x;
    val_t out_pos_y;
    val_t out_pos_z;
    val_t out_prev_x;
    val_t out_prev_y;
    val_t out_prev_z;
    val_t out_acc_x;
    val_t out_acc_y;
    val_t out_acc_z;
    logic respawned;
    logic saturated;
  } out_t;

  typedef struct packed {
    logic [DT_W-1:0] dt_squared;
    val_t            floor_height;
    val_t            ceiling_height;
    val_t            gravity_y;
  } cfg_t;

  typedef struct packed {
    prod_t x;
    prod_t y;
    prod_t z;
  } prod3_t;

  typedef struct packed {
    rnd_t x;
    rnd_t y;
    rnd_t z;
  } rnd3_t;

  typedef struct packed {
    dbl_t x;
    dbl_t y;
    dbl_t z;
  } dbl3_t;

endpackage

// ----- rtl/vps_cfg_regs.sv -----
// Configuration registers: dt_squared, floor, ceiling and respawn gravity.
module vps_cfg_regs import vps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [VAL_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_DT_SQUARED:     cfg_nxt.dt_squared     = cfg_wdata[DT_W-1:0];
        CFG_FLOOR_HEIGHT:   cfg_nxt.floor_height   = cfg_wdata;
        CFG_CEILING_HEIGHT: cfg_nxt.ceiling_height = cfg_wdata;
        CFG_GRAVITY_Y:      cfg_nxt.gravity_y      = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dt_squared     <= DT_SQUARED_RST;
      cfg_r.floor_height   <= FLOOR_HEIGHT_RST;
      cfg_r.ceiling_height <= CEILING_HEIGHT_RST;
      cfg_r.gravity_y      <= GRAVITY_Y_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/vps_mul_stage.sv -----
// Stage 1: acceleration times dt_squared per axis, exact, registered.
module vps_mul_stage import vps_pkg::*; (
  input  logic            clk,
  input  logic            adv,
  input  in_t             item,
  input  logic [DT_W-1:0] dt_squared,
  output in_t             item_r,
  output prod3_t          prod_r
);

  prod3_t prod_nxt;
  logic signed [2*VAL_W-1:0] wide_x;
  logic signed [2*VAL_W-1:0] wide_y;
  logic signed [2*VAL_W-1:0] wide_z;
  logic signed [VAL_W-1:0]   dt_s;

  // Zero-extend dt so the multiply stays signed
  assign dt_s = $signed({1'b0, dt_squared});

  always_comb begin
    wide_x = (2*VAL_W)'(item.acc_x) * (2*VAL_W)'(dt_s);
    wide_y = (2*VAL_W)'(item.acc_y) * (2*VAL_W)'(dt_s);
    wide_z = (2*VAL_W)'(item.acc_z) * (2*VAL_W)'(dt_s);
    prod_nxt.x = wide_x[PROD_W-1:0];
    prod_nxt.y = wide_y[PROD_W-1:0];
    prod_nxt.z = wide_z[PROD_W-1:0];
  end

  // Advance when the next slot frees up
  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item;
      prod_r <= prod_nxt;
    end
  end

endmodule

// ----- rtl/vps_round_stage.sv -----
// Stage 2: round the products to nearest and form 2*pos - prev per axis.
module vps_round_stage import vps_pkg::*; (
  input  logic   clk,
  input  logic   adv,
  input  in_t    item,
  input  prod3_t prod,
  output in_t    item_r,
  output rnd3_t  rnd_r,
  output dbl3_t  dbl_r
);

  localparam logic signed [PROD_W:0] HALF = (PROD_W+1)'(1) << (FRAC_BITS - 1);

  logic signed [PROD_W:0] bias_x;
  logic signed [PROD_W:0] bias_y;
  logic signed [PROD_W:0] bias_z;
  rnd3_t rnd_nxt;
  dbl3_t dbl_nxt;

  // Add half an LSB, then floor-shift by taking the upper bits
  always_comb begin
    bias_x = {prod.x[PROD_W-1], prod.x} + HALF;
    bias_y = {prod.y[PROD_W-1], prod.y} + HALF;
    bias_z = {prod.z[PROD_W-1], prod.z} + HALF;
    rnd_nxt.x = bias_x[PROD_W:FRAC_BITS];
    rnd_nxt.y = bias_y[PROD_W:FRAC_BITS];
    rnd_nxt.z = bias_z[PROD_W:FRAC_BITS];
  end

  // Double the position and subtract the previous one
  always_comb begin
    dbl_nxt.x = {item.pos_x[VAL_W-1], item.pos_x, 1'b0}
              - {{2{item.prev_x[VAL_W-1]}}, item.prev_x};
    dbl_nxt.y = {item.pos_y[VAL_W-1], item.pos_y, 1'b0}
              - {{2{item.prev_y[VAL_W-1]}}, item.prev_y};
    dbl_nxt.z = {item.pos_z[VAL_W-1], item.pos_z, 1'b0}
              - {{2{item.prev_z[VAL_W-1]}}, item.prev_z};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item;
      rnd_r  <= rnd_nxt;
      dbl_r  <= dbl_nxt;
    end
  end

endmodule

// ----- rtl/vps_final_stage.sv -----
// Stage 3: sum, saturate, floor test and respawn select into the result register.
module vps_final_stage import vps_pkg::*; (
  input  logic  clk,
  input  logic  adv,
  input  in_t   item,
  input  rnd3_t rnd,
  input  dbl3_t dbl,
  input  cfg_t  cfg,
  output out_t  res_r
);

  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [SUM_W-1:0] sum_z;
  val_t new_x;
  val_t new_y;
  val_t new_z;
  logic sat_x;
  logic sat_y;
  logic sat_z;
  logic respawn;
  out_t res_nxt;

  // Clip a full-precision sum to 32 bits
  function automatic val_t clip(input logic signed [SUM_W-1:0] s, output logic sat);
    logic hi;
    logic lo;
    hi = !s[SUM_W-1] && (|s[SUM_W-2:VAL_W-1]);
    lo = s[SUM_W-1] && !(&s[SUM_W-2:VAL_W-1]);
    sat = hi || lo;
    if (hi) begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end else if (lo) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return s[VAL_W-1:0];
    end
  endfunction

  // Add the rounded acceleration term
  always_comb begin
    sum_x = {{(SUM_W-DBL_W){dbl.x[DBL_W-1]}}, dbl.x}
          + {{(SUM_W-RND_W){rnd.x[RND_W-1]}}, rnd.x};
    sum_y = {{(SUM_W-DBL_W){dbl.y[DBL_W-1]}}, dbl.y}
          + {{(SUM_W-RND_W){rnd.y[RND_W-1]}}, rnd.y};
    sum_z = {{(SUM_W-DBL_W){dbl.z[DBL_W-1]}}, dbl.z}
          + {{(SUM_W-RND_W){rnd.z[RND_W-1]}}, rnd.z};
    new_x = clip(sum_x, sat_x);
    new_y = clip(sum_y, sat_y);
    new_z = clip(sum_z, sat_z);
  end

  // Respawn at the ceiling once the new y reaches the floor
  always_comb begin
    respawn = (new_y <= cfg.floor_height);
    res_nxt.saturated = sat_x || sat_y || sat_z;
    res_nxt.respawned = respawn;
    if (respawn) begin
      res_nxt.out_pos_x  = item.pos_x;
      res_nxt.out_pos_y  = cfg.ceiling_height;
      res_nxt.out_pos_z  = item.pos_z;
      res_nxt.out_prev_x = item.prev_x;
      res_nxt.out_prev_y = cfg.ceiling_height;
      res_nxt.out_prev_z = item.prev_z;
      res_nxt.out_acc_x  = '0;
      res_nxt.out_acc_y  = cfg.gravity_y;
      res_nxt.out_acc_z  = '0;
    end else begin
      res_nxt.out_pos_x  = new_x;
      res_nxt.out_pos_y  = new_y;
      res_nxt.out_pos_z  = new_z;
      res_nxt.out_prev_x = item.pos_x;
      res_nxt.out_prev_y = item.pos_y;
      res_nxt.out_prev_z = item.pos_z;
      res_nxt.out_acc_x  = item.acc_x;
      res_nxt.out_acc_y  = item.acc_y;
      res_nxt.out_acc_z  = item.acc_z;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ----- rtl/verlet_particle_step_floor_reset.sv -----
// Top level of the Verlet particle step with floor respawn.
//
// Input channel in_valid/in_stall/in_item carries one particle (position,
// previous position, acceleration, each x/y/z in signed Q16.16). Result
// channel out_valid/out_stall/out_item carries the stepped particle plus
// respawned and saturated flags. An item moves on an edge where valid is
// high and stall is low.
// The pipeline has four registers: input, product, rounded terms, result.
// An accepted item passes from the input register through the product,
// rounded-terms and result registers in turn. Throughput is one item per
// cycle while the result channel is not stalled.
// Each stage refills when its successor frees up, so bubbles collapse and
// in_stall rises only when all four stages hold items and the receiver
// stalls. A stalled result holds in the output register.
// The cfg_we/cfg_idx/cfg_wdata port writes dt_squared, floor_height,
// ceiling_height and gravity_y; write only while the pipeline is empty.
// Synchronous reset empties the pipeline and loads the register defaults.
module verlet_particle_step_floor_reset import vps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [VAL_W-1:0]     cfg_wdata
);

  cfg_t   cfg;
  in_t    in_r;
  in_t    s1_item;
  prod3_t s1_prod;
  in_t    s2_item;
  rnd3_t  s2_rnd;
  dbl3_t  s2_dbl;

  logic v0_r, v1_r, v2_r, v3_r;
  logic v0_nxt, v1_nxt, v2_nxt, v3_nxt;
  logic rdy0, rdy1, rdy2, rdy3;

  vps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // A stage loads when it is empty or its contents move on
  assign rdy3 = !v3_r || !out_stall;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;

  always_comb begin
    v0_nxt = rdy0 ? in_valid : v0_r;
    v1_nxt = rdy1 ? v0_r : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (rdy0) begin
      in_r <= in_item;
    end
  end

  vps_mul_stage u_mul (
    .clk        (clk),
    .adv        (rdy1),
    .item       (in_r),
    .dt_squared (cfg.dt_squared),
    .item_r     (s1_item),
    .prod_r     (s1_prod)
  );

  vps_round_stage u_rnd (
    .clk    (clk),
    .adv    (rdy2),
    .item   (s1_item),
    .prod   (s1_prod),
    .item_r (s2_item),
    .rnd_r  (s2_rnd),
    .dbl_r  (s2_dbl)
  );

  vps_final_stage u_fin (
    .clk   (clk),
    .adv   (rdy3),
    .item  (s2_item),
    .rnd   (s2_rnd),
    .dbl   (s2_dbl),
    .cfg   (cfg),
    .res_r (out_item)
  );

  assign in_stall  = !rdy0;
  assign out_valid = v3_r;

endmodule

// ----- rtl/vps_checker.sv -----
// Port-level checks for the Verlet particle step, bound to the top level.
module vps_checker import vps_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_item,
  input logic out_valid,
  input logic out_stall,
  input out_t out_item
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // Hold a stalled input item
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input item changed or dropped");

  // Drain the pipeline on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Push back only behind a valid, stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Zero x/z acceleration and match y on a respawn
  a_respawn_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.respawned |->
      out_item.out_acc_x == '0 && out_item.out_acc_z == '0 &&
      out_item.out_pos_y == out_item.out_prev_y)
    else $error("respawned result has wrong shape");

endmodule

bind verlet_particle_step_floor_reset vps_checker u_vps_checker (.*);
